// ===== hdl/lru_key_value_cache_defines.svh =====
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shared concurrent assertion helpers for the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define LKV_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define LKV_ASSERT(lbl, prop, msg) \
  `LKV_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Word types, command and status bundles and constants of the cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 7;
  localparam int ENTRIES_DEF = 64;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

  // Operation codes of the cmd field.
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] value_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESOLVE,
    ST_UPDATE
  } state_e;

  // What the update cycle does to the entry store.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_FILL,
    OP_TOUCH
  } op_e;

  typedef struct packed {
    logic accept;
    logic resolve;
    logic update;
    logic cfg_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// ===== hdl/lkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU cache controller
// Sequences accept, resolve and update of one word at a time.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  lkv_pkg::ctrl_sts_t sts_i,
  output lkv_pkg::ctrl_cmd_t cmd_o
);

  lkv_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkv_pkg::ST_IDLE: begin
        if (in_valid_i && !cfg_valid_i) state_d = lkv_pkg::ST_RESOLVE;
      end
      lkv_pkg::ST_RESOLVE: begin
        state_d = lkv_pkg::ST_UPDATE;
      end
      lkv_pkg::ST_UPDATE: begin
        if (!(sts_i.is_get && sts_i.out_busy)) state_d = lkv_pkg::ST_IDLE;
      end
      default: begin
        state_d = lkv_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs. A configuration write wins over an input word in the idle state.
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      lkv_pkg::ST_IDLE: begin
        cfg_ready_o       = 1'b1;
        in_stall_o        = cfg_valid_i;
        cmd_o.accept      = in_valid_i && !cfg_valid_i;
        cmd_o.cfg_write   = cfg_valid_i;
      end
      lkv_pkg::ST_RESOLVE: begin
        cmd_o.resolve = 1'b1;
      end
      lkv_pkg::ST_UPDATE: begin
        cmd_o.update = !(sts_i.is_get && sts_i.out_busy);
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/lkv_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU cache datapath
// Key match array, recency ranks, value RAM and the result register.
// ----------------------------------------------------------------------------
module lkv_datapath #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lkv_pkg::ctrl_cmd_t         cmd_i,
  output lkv_pkg::ctrl_sts_t         sts_o,
  input  lkv_pkg::in_item_t          in_data_i,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lkv_pkg::out_item_t         out_data_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

  // Entry store.
  logic [lkv_pkg::KEY_W-1:0]  key_q  [ENTRIES];
  logic [IW-1:0]              rank_q [ENTRIES];
  logic [lkv_pkg::DATA_W-1:0] val_mem [ENTRIES];
  logic [CW-1:0]              fill_q;
  logic [lkv_pkg::CAP_W-1:0]  cap_q;

  // Word in flight.
  lkv_pkg::in_item_t          cur_q;
  logic [ENTRIES-1:0]         match_q, match_d;
  logic [ENTRIES-1:0]         lru_q, lru_d;
  logic [IW-1:0]              target_q, target_d;
  logic [IW-1:0]              old_q, old_d;
  logic                       hit_q, hit_d;
  lkv_pkg::op_e               op_q, op_d;
  logic [lkv_pkg::DATA_W-1:0] rd_q;

  // Result register.
  logic                       out_valid_q;
  lkv_pkg::out_item_t         out_q;

  logic [IW-1:0] match_idx, lru_idx;
  logic [IW-1:0] match_rank;
  logic [EW-1:0] cap_ext, eff_cap;
  logic          has_room;

  // Compare the incoming key against every valid entry and flag the LRU one.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i] = (CW'(i) < fill_q) && (key_q[i] == in_data_i.key);
      lru_d[i]   = (CW'(i) < fill_q) && (rank_q[i] == '0);
    end
  end

  // Encode the match lines and pick the entry to work on.
  always_comb begin
    match_idx  = '0;
    lru_idx    = '0;
    match_rank = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) match_idx = IW'(i);
      if (lru_q[i])   lru_idx   = IW'(i);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      match_rank = match_rank | (match_q[i] ? rank_q[i] : '0);
    end

    cap_ext  = EW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(ENTRIES)) begin
      eff_cap = EW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    has_room = EW'(fill_q) < eff_cap;

    hit_d = |match_q;
    old_d = '0;
    if (hit_d) begin
      target_d = match_idx;
      old_d    = match_rank;
      op_d     = lkv_pkg::OP_TOUCH;
    end else if (cur_q.cmd == lkv_pkg::CMD_GET) begin
      target_d = match_idx;
      op_d     = lkv_pkg::OP_NONE;
    end else if (has_room) begin
      target_d = fill_q[IW-1:0];
      op_d     = lkv_pkg::OP_FILL;
    end else begin
      target_d = lru_idx;
      op_d     = lkv_pkg::OP_TOUCH;
    end
  end

  // Control registers: capacity and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= lkv_pkg::CAP_RESET;
      fill_q <= '0;
    end else if (cmd_i.cfg_write) begin
      cap_q  <= cfg_data_i;
      fill_q <= '0;
    end else if (cmd_i.update && op_q == lkv_pkg::OP_FILL) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // Pipeline registers of the word in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q   <= in_data_i;
      match_q <= match_d;
      lru_q   <= lru_d;
    end
    if (cmd_i.resolve) begin
      target_q <= target_d;
      old_q    <= old_d;
      hit_q    <= hit_d;
      op_q     <= op_d;
    end
  end

  // Value RAM: registered read during resolve, write during update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      rd_q <= val_mem[match_idx];
    end
    if (cmd_i.update && cur_q.cmd == lkv_pkg::CMD_PUT) begin
      val_mem[target_q] <= cur_q.value_in;
    end
  end

  // Keys and recency ranks. A touch shifts newer entries down by one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (op_q == lkv_pkg::OP_TOUCH) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if ((CW'(i) < fill_q) && (rank_q[i] > old_q)) rank_q[i] <= rank_q[i] - 1'b1;
        end
        rank_q[target_q] <= IW'(fill_q - 1'b1);
      end else if (op_q == lkv_pkg::OP_FILL) begin
        rank_q[target_q] <= fill_q[IW-1:0];
      end
      if (op_q != lkv_pkg::OP_NONE && !hit_q) begin
        key_q[target_q] <= cur_q.key;
      end
    end
  end

  // Result register for get words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update && cur_q.cmd == lkv_pkg::CMD_GET) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && cur_q.cmd == lkv_pkg::CMD_GET) begin
      out_q.hit       <= hit_q;
      out_q.value_out <= hit_q ? rd_q : lkv_pkg::MISS_VALUE;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.is_get    = (cur_q.cmd == lkv_pkg::CMD_GET);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A get result is registered at the end of update, after accept and resolve. Words are
// taken one at a time (accept with key match, resolve with value RAM read, update of ranks,
// keys and value RAM); a held result stalls only a later get.
// Reset: capacity 64 and an empty store; entry contents are not cleared, no sweep.
// Writing the capacity register empties the store.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lkv_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lkv_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data_i
);

  lkv_pkg::ctrl_cmd_t ctrl_cmd;
  lkv_pkg::ctrl_sts_t ctrl_sts;

  // Sequencer.
  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (ctrl_sts),
    .cmd_o       (ctrl_cmd)
  );

  // Entry store and result register.
  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (ctrl_sts),
    .in_data_i   (in_data_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // An accepted word never coincides with a capacity write.
  `LKV_ASSERT(a_no_cfg_with_word, (in_valid_i && !in_stall_o) |-> !(cfg_valid_i && cfg_ready_o), "word accepted during capacity write")
  // One word at a time: the cycle after an accept holds off the input.
  `LKV_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "input not held off after accept")
  // A result only appears after an update cycle.
  `LKV_ASSERT(a_result_from_update, $rose(out_valid_o) |-> $past(ctrl_cmd.update), "result without update")

endmodule
